// ----- hdl/ifd_pkg.sv -----
`timescale 1ns / 1ps

package ifd_pkg;

  // Fixed field widths
  localparam int PIX_W  = 24;
  localparam int MODE_W = 2;
  localparam int THR_W  = 7;
  localparam int MAX_W  = 24;
  localparam int LW_W   = 12;
  localparam int CNT_W  = 25;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 24;

  // Vertical step mark, two's complement coded
  typedef enum logic [1:0] {
    MARK_ZERO = 2'b00,
    MARK_UP   = 2'b01,
    MARK_DOWN = 2'b11
  } mark_e;

  // Pixel modes
  localparam logic [MODE_W-1:0] MODE_LUMA = 2'd0;
  localparam logic [MODE_W-1:0] MODE_565  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGB  = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_THR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX   = 2'd2;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  thr;
  } mark_cfg_t;

  // One line-store entry: pixel above, mark one row up, mark two rows up
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    mark_e            m1;
    mark_e            m2;
  } line_t;

endpackage

// ----- hdl/ifd_line_mem.sv -----
`timescale 1ns / 1ps

module ifd_line_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 28
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ifd_mark.sv -----
`timescale 1ns / 1ps

module ifd_mark
  import ifd_pkg::*;
(
  input  mark_cfg_t        cfg_i,
  input  logic [PIX_W-1:0] cur_i,
  input  logic [PIX_W-1:0] prv_i,
  output mark_e            mark_o
);

  logic [7:0] cur_c [3];
  logic [7:0] prv_c [3];
  logic [2:0] en;
  logic [2:0] up;
  logic [2:0] down;

  // Split into components per mode
  always_comb begin
    cur_c[0] = cur_i[7:0];
    prv_c[0] = prv_i[7:0];
    cur_c[1] = cur_i[15:8];
    prv_c[1] = prv_i[15:8];
    cur_c[2] = cur_i[23:16];
    prv_c[2] = prv_i[23:16];
    en       = 3'b111;
    case (cfg_i.mode)
      MODE_LUMA: begin
        en = 3'b001;
      end
      MODE_565: begin
        cur_c[0] = {3'b000, cur_i[4:0]};
        prv_c[0] = {3'b000, prv_i[4:0]};
        cur_c[1] = {2'b00, cur_i[10:5]};
        prv_c[1] = {2'b00, prv_i[10:5]};
        cur_c[2] = {3'b000, cur_i[15:11]};
        prv_c[2] = {3'b000, prv_i[15:11]};
      end
      default: begin
        en = 3'b111;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up[i]   = en[i] && ({1'b0, cur_c[i]} > ({1'b0, prv_c[i]} + {2'b00, cfg_i.thr}));
      down[i] = en[i] && ({1'b0, prv_c[i]} > ({1'b0, cur_c[i]} + {2'b00, cfg_i.thr}));
    end
  end

  // A rise anywhere wins over a fall
  always_comb begin
    if (|up) begin
      mark_o = MARK_UP;
    end else if (|down) begin
      mark_o = MARK_DOWN;
    end else begin
      mark_o = MARK_ZERO;
    end
  end

endmodule

// ----- hdl/interlaced_frame_detector.sv -----
`timescale 1ns / 1ps
// Result: registered in the output register when the frame's last pixel leaves stage 1.
// Throughput: one pixel per cycle unless stalled; each pixel does one read-modify-write
//   of the line store (one read port, one write port) at its column.
// A second frame end stalls input only while the previous result is still untaken.
// Reset (rst_ni low, asynchronous): registers to 0/25/31104/720, column, row, count and
//   drop history cleared; line store contents undefined until written.

module interlaced_frame_detector
  import ifd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // pixel items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             last_of_frame_i,
  // frame decision items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             pass_frame_o,
  output logic [CNT_W-1:0] interlaced_count_o,
  // configuration writes
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  // wide enough for both the column + 1 and the raw line_width register
  localparam int CW = (AW + 1 > LW_W + 1) ? AW + 1 : LW_W + 1;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [MODE_W-1:0] mode_q;
  logic [THR_W-1:0]  thr_q;
  logic [MAX_W-1:0]  max_q;
  logic [LW_W-1:0]   lw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LUMA;
      thr_q  <= THR_W'(25);
      max_q  <= MAX_W'(31104);
      lw_q   <= LW_W'(720);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  mode_q <= cfg_wdata_i[MODE_W-1:0];
        REG_THR:   thr_q  <= cfg_wdata_i[THR_W-1:0];
        REG_MAX:   max_q  <= cfg_wdata_i[MAX_W-1:0];
        REG_WIDTH: lw_q   <= cfg_wdata_i[LW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective line width: zero counts as one, clamp to the store depth
  logic [CW-1:0] lw_ext;
  logic [CW-1:0] width_eff;

  always_comb begin
    lw_ext = CW'(lw_q);
    if (lw_ext == '0) begin
      width_eff = CW'(1);
    end else if (lw_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: raster position, line store read issue
  // ------------------------------------------------------------------
  logic          in_fire;
  logic          s1_stall;
  logic [AW-1:0] col_q, col_d;
  logic [1:0]    row_q, row_d;
  logic          wrap;

  assign in_ready_o = !s1_stall;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wrap       = (CW'(col_q) + CW'(1)) >= width_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (last_of_frame_i) begin
        col_d = '0;
        row_d = '0;
      end else if (wrap) begin
        col_d = '0;
        if (row_q != 2'd3) begin
          row_d = row_q + 2'd1;
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: mark, count, write back
  // ------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_last_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_col_q;
  logic [1:0]       s1_row_q;
  logic             s1_fire;

  logic             out_valid_q;
  logic             pass_q;
  logic [CNT_W-1:0] cnt_out_q;

  // only a frame end needs the output register free
  assign s1_stall = s1_valid_q && s1_last_q && out_valid_q && !out_ready_i;
  assign s1_fire  = s1_valid_q && !s1_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q <= last_of_frame_i;
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
    end
  end

  // Line store
  line_t mem_rdata;
  line_t wr_data;
  line_t fwd_data_q;
  logic  fwd_q;
  line_t above;

  ifd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(line_t))
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  // Same column written while read (one-pixel rows): take the fresh entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_fire) begin
      fwd_q <= s1_fire && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_data_q <= wr_data;
    end
  end

  assign above = fwd_q ? fwd_data_q : mem_rdata;

  mark_cfg_t mark_cfg;
  mark_e     cmp_mark;
  mark_e     mark;

  assign mark_cfg.mode = mode_q;
  assign mark_cfg.thr  = thr_q;

  ifd_mark u_mark (
    .cfg_i  (mark_cfg),
    .cur_i  (s1_pix_q),
    .prv_i  (above.pix),
    .mark_o (cmp_mark)
  );

  // top row has nothing above it
  assign mark = (s1_row_q != 2'd0) ? cmp_mark : MARK_ZERO;

  always_comb begin
    wr_data.pix = s1_pix_q;
    wr_data.m1  = mark;
    wr_data.m2  = above.m1;
  end

  // Interlace count and drop decision
  logic [CNT_W-1:0] hit_q, hit_d;
  logic [CNT_W-1:0] cnt_new;
  logic             skipped_q, skipped_d;
  logic             hit;
  logic             pass;

  assign hit = (s1_row_q == 2'd3) && (mark == MARK_UP) &&
               ((above.m1 == MARK_DOWN) ||
                ((above.m1 == MARK_ZERO) && (above.m2 == MARK_DOWN))) &&
               (hit_q <= {1'b0, max_q});
  assign cnt_new = hit_q + CNT_W'(hit);
  assign pass    = !((cnt_new > {1'b0, max_q}) && !skipped_q);

  always_comb begin
    hit_d     = hit_q;
    skipped_d = skipped_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        hit_d     = '0;
        skipped_d = !pass;
      end else begin
        hit_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= '0;
      skipped_q <= 1'b0;
    end else begin
      hit_q     <= hit_d;
      skipped_q <= skipped_d;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      pass_q    <= pass;
      cnt_out_q <= cnt_new;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pass_frame_o       = pass_q;
  assign interlaced_count_o = cnt_out_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && s1_valid_q && s1_last_q))
    else $error("input stalled without a pending result");

  a_result_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_last_q))
    else $error("result appeared without a frame end");

  a_no_double_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q && !pass) |=> skipped_q)
    else $error("dropped frame not recorded");

endmodule
